### src/atrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrl_pkg
// shared types, request codes and aes helper functions
// ----------------------------------------------------------------------------
package atrl_pkg;

    localparam int unsigned KEY_SLOTS = 10;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_EXPLODE = 2'd1,
        REQ_IMPLODE = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_ROUND = 2'd2,
        ST_OUT   = 2'd3
    } state_t;

    typedef enum logic [1:0] {
        KW0 = 2'd0,
        KW1 = 2'd1,
        KW2 = 2'd2,
        KW3 = 2'd3
    } key_idx_t;

    // aes forward s-box
    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // one full round: shiftrows, subbytes, mixcolumns, key xor (byte i at bits 8i)
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] k);
        logic [7:0]   t [16];
        logic [127:0] r;
        logic [7:0]   a0, a1, a2, a3, x0, x1, x2, x3;
        for (int c = 0; c < 4; c++)
            for (int rr = 0; rr < 4; rr++)
                t[4*c+rr] = sbox(s[8*(4*((c+rr)%4)+rr) +: 8]);
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
            r[8*(4*c)   +: 8] = x0 ^ x1 ^ a1 ^ a2 ^ a3 ^ k[8*(4*c)   +: 8];
            r[8*(4*c+1) +: 8] = a0 ^ x1 ^ x2 ^ a2 ^ a3 ^ k[8*(4*c+1) +: 8];
            r[8*(4*c+2) +: 8] = a0 ^ a1 ^ x2 ^ x3 ^ a3 ^ k[8*(4*c+2) +: 8];
            r[8*(4*c+3) +: 8] = x0 ^ a0 ^ a1 ^ a2 ^ x3 ^ k[8*(4*c+3) +: 8];
        end
        return r;
    endfunction

endpackage

### src/atrl_key_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrl_key_sched
// aes-256 schedule into round keys, one 128-bit key per cycle into a memory
// ----------------------------------------------------------------------------
module atrl_key_sched
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_idx,
    input  logic [63:0]  cfg_data,
    input  logic [3:0]   rd_addr,
    output logic [127:0] rd_key,
    output logic         busy
);
    logic [63:0]  kw_reg [4];
    logic [127:0] prev2_reg, prev1_reg;
    logic [3:0]   cnt_reg;
    logic         run_reg;
    logic [7:0]   rc_reg;
    logic [127:0] key_mem [atrl_pkg::KEY_SLOTS];
    logic [127:0] new_key, wr_key;
    logic [31:0]  tw, w0, w1, w2, w3;

    // even slot index (>=2): rotate, sub, rcon; odd slot (>=3): sub only
    always_comb
    begin
        tw = prev1_reg[127:96];
        if (!cnt_reg[0])
            tw = atrl_pkg::sub_word({tw[7:0], tw[31:8]}) ^ {24'd0, rc_reg};
        else
            tw = atrl_pkg::sub_word(tw);
        w0 = prev2_reg[31:0] ^ tw;
        w1 = prev2_reg[63:32] ^ w0;
        w2 = prev2_reg[95:64] ^ w1;
        w3 = prev2_reg[127:96] ^ w2;
        new_key = {w3, w2, w1, w0};
        case (cnt_reg)
            4'd0:    wr_key = {kw_reg[1], kw_reg[0]};
            4'd1:    wr_key = {kw_reg[3], kw_reg[2]};
            default: wr_key = new_key;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) kw_reg[i] <= '0;
            cnt_reg <= '0;
            run_reg <= 1'b1;
            rc_reg  <= 8'h01;
        end
        else if (cfg_we)
        begin
            kw_reg[cfg_idx] <= cfg_data;
            cnt_reg <= '0;
            run_reg <= 1'b1;
            rc_reg  <= 8'h01;
        end
        else if (run_reg)
        begin
            if (cnt_reg >= 4'd2 && !cnt_reg[0]) rc_reg <= atrl_pkg::xtime(rc_reg);
            if (cnt_reg == 4'(atrl_pkg::KEY_SLOTS - 1)) run_reg <= 1'b0;
            cnt_reg <= cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_reg && !cfg_we)
        begin
            key_mem[cnt_reg] <= wr_key;
            prev2_reg <= prev1_reg;
            prev1_reg <= wr_key;
        end
        rd_key <= key_mem[rd_addr];
    end

    assign busy = run_reg;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> cnt_reg < 4'(atrl_pkg::KEY_SLOTS)) else $error("key count range");
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> run_reg && cnt_reg == 4'd0) else $error("key restart");
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg && !cfg_we && cnt_reg == 4'(atrl_pkg::KEY_SLOTS - 1) |=> !run_reg)
        else $error("key finish");
`endif
endmodule

### src/aes_ten_round_lane_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_ten_round_lane_transform
// ten-round aes transform over a small memory of 128-bit text lanes
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request: req_type (load, explode, implode), lane and a
//   128-bit block. m_axis returns one item per request: the lane's new value,
//   or zero for an unused code or out-of-range lane.
//   cfg_we/cfg_idx/cfg_data write the four 64-bit key words; each write
//   re-expands the schedule into a key memory, and no request is taken
//   while that runs.
// timing:
//   a load goes through ST_READ to ST_OUT with its block as the result; explode
//   and implode go from ST_READ through ROUND_COUNT rounds in ST_ROUND on the
//   one shared round unit that does one round per cycle with the round key
//   read from the key memory. one request is in flight at a time, so no new
//   request is taken until the result has been accepted.
// reset:
//   the key returns to zero and its schedule is rebuilt; lane memory
//   content is undefined until loaded.
// stall:
//   the result register holds until m_axis_tready; no new request is taken
//   meanwhile.
// ----------------------------------------------------------------------------
module aes_ten_round_lane_transform
#(
    parameter int LANE_COUNT  = 8,
    parameter int ROUND_COUNT = 10
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type[1:0], lane[4:2], data_lo[68:5], data_hi[132:69], zero fill
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_lo[63:0], out_hi[127:64]
    output logic [127:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_idx,
    input  logic [63:0]  cfg_data
);
    localparam int AW = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
    localparam int RW = $clog2(ROUND_COUNT + 1);

    atrl_pkg::state_t state_reg, state_next;
    logic [127:0] lane_mem [LANE_COUNT];
    logic [127:0] rd_data, st_reg, st_next, blk_reg, res_reg, res_next;
    logic [AW-1:0] lane_reg;
    logic [1:0]    req_reg;
    logic [RW-1:0] rnd_reg, rnd_next;
    logic [127:0]  rkey;
    logic          ks_busy, mem_we;
    logic [1:0]    in_req;
    logic [2:0]    in_lane;
    logic          in_ok;

    assign in_req  = s_axis_tdata[1:0];
    assign in_lane = s_axis_tdata[4:2];
    assign in_ok   = (32'(in_lane) < LANE_COUNT) && (in_req != atrl_pkg::REQ_NONE);

    // round r (rnd_reg = r) uses key r - 1, fetched while rnd_reg is r - 1
    atrl_key_sched u_ks
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .rd_addr  (4'(rnd_reg)),
        .rd_key   (rkey),
        .busy     (ks_busy)
    );

    assign s_axis_tready = (state_reg == atrl_pkg::ST_IDLE) && !ks_busy;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        rnd_next   = '0;
        res_next   = res_reg;
        mem_we     = 1'b0;
        case (state_reg)
            atrl_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    if (!in_ok)
                    begin
                        res_next   = '0;
                        state_next = atrl_pkg::ST_OUT;
                    end
                    else
                        state_next = atrl_pkg::ST_READ;
                end
            end
            atrl_pkg::ST_READ:
            begin
                // lane memory data arrives now
                if (req_reg == atrl_pkg::REQ_LOAD)
                begin
                    res_next   = blk_reg;
                    mem_we     = 1'b1;
                    state_next = atrl_pkg::ST_OUT;
                end
                else
                begin
                    st_next    = (req_reg == atrl_pkg::REQ_IMPLODE) ? rd_data ^ blk_reg
                                                                   : rd_data;
                    rnd_next   = RW'(1);
                    state_next = atrl_pkg::ST_ROUND;
                end
            end
            atrl_pkg::ST_ROUND:
            begin
                st_next  = atrl_pkg::enc_round(st_reg, rkey);
                rnd_next = rnd_reg + RW'(1);
                if (rnd_reg == RW'(ROUND_COUNT))
                begin
                    res_next   = st_next;
                    mem_we     = 1'b1;
                    state_next = atrl_pkg::ST_OUT;
                end
            end
            atrl_pkg::ST_OUT:
            begin
                if (m_axis_tready) state_next = atrl_pkg::ST_IDLE;
            end
            default: state_next = atrl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= atrl_pkg::ST_IDLE;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            lane_reg <= AW'(in_lane);
            req_reg  <= in_req;
            blk_reg  <= s_axis_tdata[132:5];
        end
        st_reg  <= st_next;
        res_reg <= res_next;
    end

    // lane memory: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (mem_we) lane_mem[lane_reg] <= res_next;
        rd_data <= lane_mem[AW'(in_lane)];
    end

    assign m_axis_tvalid = (state_reg == atrl_pkg::ST_OUT);
    assign m_axis_tdata  = res_reg;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("request while busy");
    a_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == atrl_pkg::ST_ROUND |-> rnd_reg <= RW'(ROUND_COUNT))
        else $error("round overrun");
`endif
endmodule
